// ===== rtl/nsd_pkg.sv =====
package nsd_pkg;

	localparam int BYTE_DEPTH    = 64;
	localparam int SESSION_DEPTH = 128;
	localparam int LENGTH_WIDTH  = 16;

	localparam int BYTE_AW = $clog2(BYTE_DEPTH);
	localparam int BYTE_FW = $clog2(BYTE_DEPTH + 1);
	localparam int SESS_AW = $clog2(SESSION_DEPTH);
	localparam int SESS_FW = $clog2(SESSION_DEPTH + 1);

	localparam int REQ_W        = 2;
	localparam int NIB_W        = 4;
	localparam int BYTE_W       = 8;
	localparam int LEN_OUT_W    = 16;
	localparam int BYTES_HELD_W = 7;
	localparam int SESS_HELD_W  = 8;

	localparam int CMD_DEPTH = 2;
	localparam int CMD_AW    = $clog2(CMD_DEPTH);
	localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_NIBBLE   = 2'd0,
		REQ_POP_BYTE = 2'd1,
		REQ_POP_LEN  = 2'd2,
		REQ_IDLE     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		OP_NONE     = 3'd0,
		OP_PUSH     = 3'd1,
		OP_CLOSE    = 3'd2,
		OP_POP_BYTE = 3'd3,
		OP_POP_LEN  = 3'd4
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic                    byte_valid;
		logic [BYTE_W-1:0]       data_byte;
		logic                    length_valid;
		logic [LEN_OUT_W-1:0]    session_length;
		logic                    session_closed;
		logic                    byte_dropped;
		logic                    length_overflow;
		logic [BYTES_HELD_W-1:0] bytes_held;
		logic [SESS_HELD_W-1:0]  sessions_held;
	} rsp_t;

endpackage

// ===== rtl/nsd_req_if.sv =====
interface nsd_req_if;
	logic                        valid;
	logic                        ready;
	logic [nsd_pkg::REQ_W-1:0]   req_type;
	logic [nsd_pkg::NIB_W-1:0]   nibble;

	modport source (output valid, req_type, nibble, input ready);
	modport sink (input valid, req_type, nibble, output ready);
endinterface

// ===== rtl/nsd_rsp_if.sv =====
interface nsd_rsp_if;
	logic                               valid;
	logic                               ready;
	logic                               byte_valid;
	logic [nsd_pkg::BYTE_W-1:0]         data_byte;
	logic                               length_valid;
	logic [nsd_pkg::LEN_OUT_W-1:0]      session_length;
	logic                               session_closed;
	logic                               byte_dropped;
	logic                               length_overflow;
	logic [nsd_pkg::BYTES_HELD_W-1:0]   bytes_held;
	logic [nsd_pkg::SESS_HELD_W-1:0]    sessions_held;

	modport source (
		output valid, byte_valid, data_byte, length_valid, session_length,
		output session_closed, byte_dropped, length_overflow, bytes_held, sessions_held,
		input ready
	);
	modport sink (
		input valid, byte_valid, data_byte, length_valid, session_length,
		input session_closed, byte_dropped, length_overflow, bytes_held, sessions_held,
		output ready
	);
endinterface

// ===== rtl/nsd_ram.sv =====
module nsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/nsd_front.sv =====
module nsd_front (
	input  logic            clk,
	input  logic            arst_n,
	nsd_req_if.sink         request,
	output logic            cmd_valid,
	input  logic            cmd_ready,
	output nsd_pkg::cmd_t   cmd
);

	logic                       low_next_q;
	logic [nsd_pkg::NIB_W-1:0]  high_q;
	logic                       accept;
	logic [nsd_pkg::BYTE_W-1:0] byte_val;

	assign request.ready = cmd_ready;
	assign accept        = request.valid && cmd_ready;
	assign cmd_valid     = request.valid;
	assign byte_val      = {high_q, request.nibble};

	always_comb begin
		cmd.data = byte_val;
		cmd.op   = nsd_pkg::OP_NONE;
		unique case (nsd_pkg::req_t'(request.req_type))
			nsd_pkg::REQ_NIBBLE: begin
				if (low_next_q) begin
					cmd.op = (byte_val == '0) ? nsd_pkg::OP_CLOSE : nsd_pkg::OP_PUSH;
				end
			end
			nsd_pkg::REQ_POP_BYTE: cmd.op = nsd_pkg::OP_POP_BYTE;
			nsd_pkg::REQ_POP_LEN:  cmd.op = nsd_pkg::OP_POP_LEN;
			nsd_pkg::REQ_IDLE:     cmd.op = nsd_pkg::OP_NONE;
		endcase
	end

	// nibble pairing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_next_q <= 1'b0;
			high_q     <= '0;
		end else if (accept && nsd_pkg::req_t'(request.req_type) == nsd_pkg::REQ_NIBBLE) begin
			if (!low_next_q) begin
				high_q <= request.nibble;
			end
			low_next_q <= !low_next_q;
		end
	end

endmodule

// ===== rtl/nsd_cmd_fifo.sv =====
module nsd_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  nsd_pkg::cmd_t   push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output nsd_pkg::cmd_t   pop_cmd
);

	nsd_pkg::cmd_t                entry_q [nsd_pkg::CMD_DEPTH];
	logic [nsd_pkg::CMD_AW-1:0]   wr_q;
	logic [nsd_pkg::CMD_AW-1:0]   rd_q;
	logic [nsd_pkg::CMD_CW-1:0]   cnt_q;
	logic                         push;
	logic                         pop;

	assign push_ready = cnt_q != nsd_pkg::CMD_CW'(nsd_pkg::CMD_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == nsd_pkg::CMD_AW'(nsd_pkg::CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == nsd_pkg::CMD_AW'(nsd_pkg::CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/nsd_back.sv =====
module nsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  nsd_pkg::cmd_t   cmd,
	nsd_rsp_if.source       result
);

	logic [nsd_pkg::BYTE_AW-1:0]      brd_q, bwr_q, brd_n, bwr_n;
	logic [nsd_pkg::BYTE_FW-1:0]      bfill_q, bfill_n;
	logic [nsd_pkg::SESS_AW-1:0]      lrd_q, lwr_q, lrd_n, lwr_n;
	logic [nsd_pkg::SESS_FW-1:0]      lfill_q, lfill_n;
	logic [nsd_pkg::LENGTH_WIDTH-1:0] open_len_q, open_len_n;

	logic                             bwe, lwe;
	logic [nsd_pkg::BYTE_W-1:0]       brdata;
	logic [nsd_pkg::LENGTH_WIDTH-1:0] lrdata;

	logic                             issue;
	nsd_pkg::rsp_t                    rsp_n;
	logic                             valid_s1;
	nsd_pkg::rsp_t                    rsp_s1;
	nsd_pkg::rsp_t                    rsp_done;

	nsd_pkg::rsp_t                    out_q [nsd_pkg::OUT_DEPTH];
	logic [nsd_pkg::OUT_AW-1:0]       owr_q, ord_q;
	logic [nsd_pkg::OUT_CW-1:0]       ocnt_q;
	logic [nsd_pkg::OUT_CW:0]         out_used;
	logic                             out_pop;
	nsd_pkg::rsp_t                    out_head;

	// issue only when the result buffer has a free slot for this transaction
	assign out_used  = {1'b0, ocnt_q} + {{nsd_pkg::OUT_CW{1'b0}}, valid_s1};
	assign issue     = cmd_valid && (out_used < (nsd_pkg::OUT_CW + 1)'(nsd_pkg::OUT_DEPTH));
	assign cmd_ready = issue;

	always_comb begin
		brd_n      = brd_q;
		bwr_n      = bwr_q;
		bfill_n    = bfill_q;
		lrd_n      = lrd_q;
		lwr_n      = lwr_q;
		lfill_n    = lfill_q;
		open_len_n = open_len_q;
		bwe        = 1'b0;
		lwe        = 1'b0;
		rsp_n      = '0;
		if (issue) begin
			unique case (cmd.op)
				nsd_pkg::OP_PUSH: begin
					if (bfill_q == nsd_pkg::BYTE_FW'(nsd_pkg::BYTE_DEPTH)) begin
						rsp_n.byte_dropped = 1'b1;
					end else begin
						bwe     = 1'b1;
						bwr_n   = (bwr_q == nsd_pkg::BYTE_AW'(nsd_pkg::BYTE_DEPTH - 1)) ?
							'0 : bwr_q + 1'b1;
						bfill_n = bfill_q + 1'b1;
						if (open_len_q != '1) begin
							open_len_n = open_len_q + 1'b1;
						end
					end
				end
				nsd_pkg::OP_CLOSE: begin
					rsp_n.session_closed = 1'b1;
					if (lfill_q == nsd_pkg::SESS_FW'(nsd_pkg::SESSION_DEPTH)) begin
						rsp_n.length_overflow = 1'b1;
					end else begin
						lwe     = 1'b1;
						lwr_n   = (lwr_q == nsd_pkg::SESS_AW'(nsd_pkg::SESSION_DEPTH - 1)) ?
							'0 : lwr_q + 1'b1;
						lfill_n = lfill_q + 1'b1;
					end
					open_len_n = '0;
				end
				nsd_pkg::OP_POP_BYTE: begin
					if (bfill_q != '0) begin
						rsp_n.byte_valid = 1'b1;
						brd_n   = (brd_q == nsd_pkg::BYTE_AW'(nsd_pkg::BYTE_DEPTH - 1)) ?
							'0 : brd_q + 1'b1;
						bfill_n = bfill_q - 1'b1;
					end
				end
				nsd_pkg::OP_POP_LEN: begin
					if (lfill_q != '0) begin
						rsp_n.length_valid = 1'b1;
						lrd_n   = (lrd_q == nsd_pkg::SESS_AW'(nsd_pkg::SESSION_DEPTH - 1)) ?
							'0 : lrd_q + 1'b1;
						lfill_n = lfill_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
		rsp_n.bytes_held    = nsd_pkg::BYTES_HELD_W'(bfill_n);
		rsp_n.sessions_held = nsd_pkg::SESS_HELD_W'(lfill_n);
	end

	nsd_ram #(
		.WIDTH (nsd_pkg::BYTE_W),
		.DEPTH (nsd_pkg::BYTE_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (bwe),
		.waddr (bwr_q),
		.wdata (cmd.data),
		.raddr (brd_q),
		.rdata (brdata)
	);

	nsd_ram #(
		.WIDTH (nsd_pkg::LENGTH_WIDTH),
		.DEPTH (nsd_pkg::SESSION_DEPTH)
	) u_len_ram (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwr_q),
		.wdata (open_len_q),
		.raddr (lrd_q),
		.rdata (lrdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brd_q      <= '0;
			bwr_q      <= '0;
			bfill_q    <= '0;
			lrd_q      <= '0;
			lwr_q      <= '0;
			lfill_q    <= '0;
			open_len_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			brd_q      <= brd_n;
			bwr_q      <= bwr_n;
			bfill_q    <= bfill_n;
			lrd_q      <= lrd_n;
			lwr_q      <= lwr_n;
			lfill_q    <= lfill_n;
			open_len_q <= open_len_n;
			valid_s1   <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rsp_s1 <= rsp_n;
		end
	end

	// merge memory read data into the transaction
	always_comb begin
		rsp_done                = rsp_s1;
		rsp_done.data_byte      = rsp_s1.byte_valid ? brdata : '0;
		rsp_done.session_length = rsp_s1.length_valid ?
			nsd_pkg::LEN_OUT_W'(lrdata) : '0;
	end

	// result buffer
	assign out_pop  = result.valid && result.ready;
	assign out_head = out_q[ord_q];

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_q[owr_q] <= rsp_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1) begin
				owr_q <= (owr_q == nsd_pkg::OUT_AW'(nsd_pkg::OUT_DEPTH - 1)) ? '0 : owr_q + 1'b1;
			end
			if (out_pop) begin
				ord_q <= (ord_q == nsd_pkg::OUT_AW'(nsd_pkg::OUT_DEPTH - 1)) ? '0 : ord_q + 1'b1;
			end
			if (valid_s1 && !out_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (out_pop && !valid_s1) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	assign result.valid           = ocnt_q != '0;
	assign result.byte_valid      = out_head.byte_valid;
	assign result.data_byte       = out_head.data_byte;
	assign result.length_valid    = out_head.length_valid;
	assign result.session_length  = out_head.session_length;
	assign result.session_closed  = out_head.session_closed;
	assign result.byte_dropped    = out_head.byte_dropped;
	assign result.length_overflow = out_head.length_overflow;
	assign result.bytes_held      = out_head.bytes_held;
	assign result.sessions_held   = out_head.sessions_held;

endmodule

// ===== rtl/nibble_stream_deframer.sv =====
// channel   dir  handshake     payload
// request   in   valid/ready   req_type, nibble
// result    out  valid/ready   byte_valid, data_byte, length_valid, session_length,
//                              session_closed, byte_dropped, length_overflow,
//                              bytes_held, sessions_held
//
// one transaction per cycle sustained while results are taken; every
// request gives exactly one result, which passes the command queue, issue with
// byte/length memory read and read data merge into the result buffer
// arst_n clears all four fifos, the open length and the nibble pairing state
// result stalls fill the 4-entry result buffer, then the 2-entry command queue,
// then request.ready drops
module nibble_stream_deframer (
	input  logic       clk,
	input  logic       arst_n,
	nsd_req_if.sink    request,
	nsd_rsp_if.source  result
);

	logic           front_valid;
	logic           front_ready;
	nsd_pkg::cmd_t  front_cmd;
	logic           back_valid;
	logic           back_ready;
	nsd_pkg::cmd_t  back_cmd;

	nsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	nsd_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	nsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.result    (result)
	);

endmodule

// ===== tb/sv/nibble_stream_deframer_tb.sv =====
module nibble_stream_deframer_tb;
	import nsd_pkg::*;

	logic clk;
	logic arst_n;

	nsd_req_if req_ch ();
	nsd_rsp_if rsp_ch ();

	nibble_stream_deframer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (rsp_ch)
	);

	int err_count;
	int send_idle_pct;
	int recv_stall_pct;

	// deframer shadow state
	bit                      pair_low;
	logic [NIB_W-1:0]        hi_nib;
	logic [BYTE_W-1:0]       byte_mem [BYTE_DEPTH];
	int                      byte_rd;
	int                      byte_cnt;
	logic [LENGTH_WIDTH-1:0] open_len;
	logic [LENGTH_WIDTH-1:0] len_mem [SESSION_DEPTH];
	int                      len_rd;
	int                      len_cnt;

	rsp_t rsp_owed [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t deframe_step(req_t kind, logic [NIB_W-1:0] nib);
		rsp_t              r;
		logic [BYTE_W-1:0] b;
		r = '0;
		case (kind)
			REQ_NIBBLE: begin
				if (!pair_low) begin
					hi_nib   = nib;
					pair_low = 1'b1;
				end else begin
					pair_low = 1'b0;
					b = {hi_nib, nib};
					if (b == '0) begin
						r.session_closed = 1'b1;
						if (len_cnt >= SESSION_DEPTH) begin
							r.length_overflow = 1'b1;
						end else begin
							len_mem[(len_rd + len_cnt) % SESSION_DEPTH] = open_len;
							len_cnt++;
						end
						open_len = '0;
					end else if (byte_cnt >= BYTE_DEPTH) begin
						r.byte_dropped = 1'b1;
					end else begin
						byte_mem[(byte_rd + byte_cnt) % BYTE_DEPTH] = b;
						byte_cnt++;
						if (open_len != '1)
							open_len++;
					end
				end
			end
			REQ_POP_BYTE: begin
				if (byte_cnt > 0) begin
					r.byte_valid = 1'b1;
					r.data_byte  = byte_mem[byte_rd];
					byte_rd      = (byte_rd + 1) % BYTE_DEPTH;
					byte_cnt--;
				end
			end
			REQ_POP_LEN: begin
				if (len_cnt > 0) begin
					r.length_valid   = 1'b1;
					r.session_length = LEN_OUT_W'(len_mem[len_rd]);
					len_rd           = (len_rd + 1) % SESSION_DEPTH;
					len_cnt--;
				end
			end
			default: begin
			end
		endcase
		r.bytes_held    = BYTES_HELD_W'(byte_cnt);
		r.sessions_held = SESS_HELD_W'(len_cnt);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (err_count < 100)
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic check_result();
		rsp_t got;
		rsp_t want;
		got.byte_valid      = rsp_ch.byte_valid;
		got.data_byte       = rsp_ch.data_byte;
		got.length_valid    = rsp_ch.length_valid;
		got.session_length  = rsp_ch.session_length;
		got.session_closed  = rsp_ch.session_closed;
		got.byte_dropped    = rsp_ch.byte_dropped;
		got.length_overflow = rsp_ch.length_overflow;
		got.bytes_held      = rsp_ch.bytes_held;
		got.sessions_held   = rsp_ch.sessions_held;
		if (rsp_owed.size() == 0) begin
			report_mismatch("result with none outstanding", 1, 0);
		end else begin
			want = rsp_owed.pop_front();
			if (got.byte_valid !== want.byte_valid)
				report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
			if (got.data_byte !== want.data_byte)
				report_mismatch("data_byte", got.data_byte, want.data_byte);
			if (got.length_valid !== want.length_valid)
				report_mismatch("length_valid", got.length_valid, want.length_valid);
			if (got.session_length !== want.session_length)
				report_mismatch("session_length", got.session_length, want.session_length);
			if (got.session_closed !== want.session_closed)
				report_mismatch("session_closed", got.session_closed, want.session_closed);
			if (got.byte_dropped !== want.byte_dropped)
				report_mismatch("byte_dropped", got.byte_dropped, want.byte_dropped);
			if (got.length_overflow !== want.length_overflow)
				report_mismatch("length_overflow", got.length_overflow, want.length_overflow);
			if (got.bytes_held !== want.bytes_held)
				report_mismatch("bytes_held", got.bytes_held, want.bytes_held);
			if (got.sessions_held !== want.sessions_held)
				report_mismatch("sessions_held", got.sessions_held, want.sessions_held);
		end
	endtask

	// result side: check each transaction, then stall at random
	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			check_result();
		rsp_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_req(req_t kind, logic [NIB_W-1:0] nib);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.nibble   <= nib;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		rsp_owed.push_back(deframe_step(kind, nib));
	endtask

	task automatic send_byte(logic [BYTE_W-1:0] b);
		send_req(REQ_NIBBLE, b[7:4]);
		send_req(REQ_NIBBLE, b[3:0]);
	endtask

	task automatic align_byte();
		if (pair_low)
			send_req(REQ_NIBBLE, NIB_W'($urandom_range(15)));
	endtask

	function automatic logic [BYTE_W-1:0] any_nonzero_byte();
		return {NIB_W'($urandom_range(1, 15)), NIB_W'($urandom_range(15))};
	endfunction

	task automatic test_directed();
		send_req(REQ_POP_BYTE, 4'h0);
		send_req(REQ_POP_LEN, 4'hF);
		send_req(REQ_IDLE, 4'h0);
		send_req(REQ_NIBBLE, 4'h0);
		send_req(REQ_NIBBLE, 4'h0);
		send_req(REQ_POP_LEN, 4'h0);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h10);
		send_req(REQ_NIBBLE, 4'hA);
		send_req(REQ_IDLE, 4'hF);
		send_req(REQ_POP_BYTE, 4'h0);
		send_req(REQ_POP_LEN, 4'h0);
		send_req(REQ_NIBBLE, 4'h5);
		send_byte(8'h00);
		repeat (5) send_req(REQ_POP_BYTE, 4'h0);
		send_req(REQ_POP_LEN, 4'h0);
		send_req(REQ_POP_LEN, 4'h0);
	endtask

	task automatic test_byte_overflow();
		align_byte();
		while (byte_cnt < BYTE_DEPTH)
			send_byte(any_nonzero_byte());
		repeat (3) send_byte(any_nonzero_byte());
		send_byte(8'h00);
		while (byte_cnt > 0)
			send_req(REQ_POP_BYTE, NIB_W'($urandom_range(15)));
		send_req(REQ_POP_BYTE, 4'h0);
	endtask

	task automatic test_length_overflow();
		align_byte();
		while (len_cnt < SESSION_DEPTH)
			send_byte(8'h00);
		send_byte(any_nonzero_byte());
		repeat (3) send_byte(8'h00);
		while (len_cnt > 0)
			send_req(REQ_POP_LEN, NIB_W'($urandom_range(15)));
		send_req(REQ_POP_LEN, 4'h0);
	endtask

	task automatic test_random(int count);
		int mode;
		int pick;
		int pop_byte_pct;
		int pop_len_pct;
		mode = 0;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0)
				mode = $urandom_range(2);
			// fill-heavy, balanced and drain-heavy stretches
			case (mode)
				0:       begin pop_byte_pct = 5;  pop_len_pct = 3;  end
				1:       begin pop_byte_pct = 20; pop_len_pct = 12; end
				default: begin pop_byte_pct = 35; pop_len_pct = 20; end
			endcase
			pick = $urandom_range(99);
			if (pick < pop_byte_pct)
				send_req(REQ_POP_BYTE, NIB_W'($urandom_range(15)));
			else if (pick < pop_byte_pct + pop_len_pct)
				send_req(REQ_POP_LEN, NIB_W'($urandom_range(15)));
			else if (pick < pop_byte_pct + pop_len_pct + 8)
				send_req(REQ_IDLE, NIB_W'($urandom_range(15)));
			else if ($urandom_range(3) == 0)
				send_req(REQ_NIBBLE, 4'h0);
			else
				send_req(REQ_NIBBLE, NIB_W'($urandom_range(15)));
		end
	endtask

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		err_count       = 0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = REQ_IDLE;
		req_ch.nibble   = '0;
		rsp_ch.ready    = 1'b0;
		pair_low        = 1'b0;
		hi_nib          = '0;
		byte_rd         = 0;
		byte_cnt        = 0;
		open_len        = '0;
		len_rd          = 0;
		len_cnt         = 0;
		send_idle_pct   = 8;
		recv_stall_pct  = 88;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_byte_overflow();
		test_random(210);

		send_idle_pct  = 88;
		recv_stall_pct = 8;
		test_length_overflow();
		test_random(210);

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random(210);

		req_ch.valid <= 1'b0;
		while (rsp_owed.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
